[rtl/pft_pkg.sv]
package pft_pkg;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

	typedef enum logic [2:0] {
		PH_TAG    = 3'd0,
		PH_VARINT = 3'd1,
		PH_FIXED  = 3'd2,
		PH_LEN    = 3'd3,
		PH_SKIP   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_VARINT  = 2'd0,
		KIND_FIXED64 = 2'd1,
		KIND_LEN     = 2'd2,
		KIND_FIXED32 = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_FIELD = 3'd0,
		ST_END   = 3'd1,
		ST_TRUNC = 3'd2,
		ST_LONG  = 3'd3,
		ST_ZERO  = 3'd4,
		ST_WIRE  = 3'd5,
		ST_TAG   = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_final;
	} in_t;

	typedef struct packed {
		logic [28:0] field_id;
		logic [1:0]  field_kind;
		logic [63:0] field_value;
		logic [31:0] payload_offset;
		logic [31:0] payload_length;
		logic [2:0]  status;
		logic        end_of_message;
	} out_t;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] acc;
		logic [3:0]  count;
		logic [28:0] fnum;
		kind_t       kind;
		logic [31:0] remaining;
		logic [31:0] pstart;
		logic        stopped;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:     PH_TAG,
		acc:       64'd0,
		count:     4'd0,
		fnum:      29'd0,
		kind:      KIND_VARINT,
		remaining: 32'd0,
		pstart:    32'd0,
		stopped:   1'b0
	};

endpackage

[rtl/pft_step.sv]
module pft_step (
	input  pft_pkg::state_t cur,
	input  pft_pkg::in_t    beat,
	input  logic [31:0]     pos_low,
	output pft_pkg::state_t nxt,
	output logic            rec_valid,
	output pft_pkg::out_t   rec
);
	import pft_pkg::*;

	logic [7:0]  b;
	logic        fin;
	logic [6:0]  sh7;
	logic [63:0] acc_v;
	logic [3:0]  cnt_v;
	logic        v_done;
	logic        v_long;
	logic [63:0] acc_f;
	logic [3:0]  cnt_f;
	logic        f_done;
	logic [31:0] rem_dec;
	logic [28:0] tag_fn;
	logic        wt_ok;
	kind_t       wt_kind;
	phase_t      wt_phase;
	status_t     code;

	assign b   = beat.in_byte;
	assign fin = beat.in_final;

	assign sh7    = {3'b000, cur.count} * 7'd7;
	assign acc_v  = (cur.count < VARINT_MAX_BYTES) ?
		(cur.acc | ({57'd0, b[6:0]} << sh7[5:0])) : cur.acc;
	assign cnt_v  = (cur.count < VARINT_MAX_BYTES) ? cur.count + 4'd1 : cur.count;
	assign v_done = !b[7];
	assign v_long = b[7] && (cnt_v >= VARINT_MAX_BYTES);

	assign acc_f  = cur.acc | ({56'd0, b} << {cur.count[2:0], 3'b000});
	assign cnt_f  = cur.count + 4'd1;
	assign f_done = cnt_f >= ((cur.kind == KIND_FIXED64) ? 4'd8 : 4'd4);

	assign rem_dec = (cur.remaining != 32'd0) ? cur.remaining - 32'd1 : cur.remaining;
	assign tag_fn  = acc_v[31:3];

	always_comb begin
		wt_ok    = 1'b1;
		wt_kind  = KIND_VARINT;
		wt_phase = PH_VARINT;
		unique case (acc_v[2:0])
			WT_VARINT: begin
				wt_kind  = KIND_VARINT;
				wt_phase = PH_VARINT;
			end
			WT_FIXED64: begin
				wt_kind  = KIND_FIXED64;
				wt_phase = PH_FIXED;
			end
			WT_LEN: begin
				wt_kind  = KIND_LEN;
				wt_phase = PH_LEN;
			end
			WT_FIXED32: begin
				wt_kind  = KIND_FIXED32;
				wt_phase = PH_FIXED;
			end
			default: wt_ok = 1'b0;
		endcase
	end

	// The record decision: whether this beat yields a record and which status it has.
	always_comb begin
		rec_valid = 1'b0;
		code      = ST_FIELD;
		if (cur.stopped) begin
			rec_valid = fin;
			code      = ST_END;
		end else begin
			unique case (cur.phase)
				PH_TAG: begin
					if (v_long) begin
						rec_valid = 1'b1;
						code      = ST_LONG;
					end else if (v_done) begin
						if (acc_v[63:32] != 32'd0) begin
							rec_valid = 1'b1;
							code      = ST_TAG;
						end else if (tag_fn == 29'd0) begin
							rec_valid = 1'b1;
							code      = ST_ZERO;
						end else if (!wt_ok) begin
							rec_valid = 1'b1;
							code      = ST_WIRE;
						end
					end
				end
				PH_VARINT: begin
					if (v_long) begin
						rec_valid = 1'b1;
						code      = ST_LONG;
					end else if (v_done) begin
						rec_valid = 1'b1;
						code      = ST_FIELD;
					end
				end
				PH_FIXED: begin
					rec_valid = f_done;
					code      = ST_FIELD;
				end
				PH_LEN: begin
					if (v_long) begin
						rec_valid = 1'b1;
						code      = ST_LONG;
					end else if (v_done) begin
						if (acc_v[63:32] != 32'd0) begin
							rec_valid = 1'b1;
							code      = ST_TRUNC;
						end else if (acc_v[31:0] == 32'd0) begin
							rec_valid = 1'b1;
							code      = ST_FIELD;
						end
					end
				end
				PH_SKIP: begin
					rec_valid = (rem_dec == 32'd0);
					code      = ST_FIELD;
				end
				default: begin
					rec_valid = 1'b0;
					code      = ST_FIELD;
				end
			endcase
			if (!rec_valid && fin) begin
				rec_valid = 1'b1;
				code      = ST_TRUNC;
			end
		end
	end

	always_comb begin
		nxt = cur;
		if (!cur.stopped) begin
			unique case (cur.phase)
				PH_TAG: begin
					nxt.acc   = acc_v;
					nxt.count = cnt_v;
					if (v_done && !v_long) begin
						nxt.acc   = 64'd0;
						nxt.count = 4'd0;
						nxt.fnum  = tag_fn;
						if (wt_ok) begin
							nxt.kind  = wt_kind;
							nxt.phase = wt_phase;
						end
					end
				end
				PH_VARINT: begin
					nxt.acc   = acc_v;
					nxt.count = cnt_v;
				end
				PH_FIXED: begin
					nxt.acc   = acc_f;
					nxt.count = cnt_f;
				end
				PH_LEN: begin
					nxt.acc   = acc_v;
					nxt.count = cnt_v;
					if (v_done && !v_long) begin
						nxt.pstart    = pos_low;
						nxt.remaining = acc_v[31:0];
						if (acc_v[31:0] != 32'd0) begin
							nxt.phase = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					nxt.remaining = rem_dec;
				end
				default: begin
					nxt.phase = PH_TAG;
				end
			endcase
			if (rec_valid) begin
				if (code == ST_FIELD) begin
					nxt.phase     = PH_TAG;
					nxt.acc       = 64'd0;
					nxt.count     = 4'd0;
					nxt.remaining = 32'd0;
				end else begin
					nxt.stopped = 1'b1;
				end
			end
		end
		if (fin) begin
			nxt = STATE_RESET;
		end
	end

	always_comb begin
		rec                = '0;
		rec.status         = code;
		rec.end_of_message = fin;
		if (code == ST_FIELD) begin
			rec.field_id   = cur.fnum;
			rec.field_kind = cur.kind;
			if (cur.kind == KIND_LEN) begin
				if (cur.phase == PH_LEN) begin
					rec.payload_offset = pos_low;
					rec.payload_length = acc_v[31:0];
				end else begin
					rec.payload_offset = cur.pstart;
					rec.payload_length = cur.acc[31:0];
				end
			end else if (cur.phase == PH_FIXED) begin
				rec.field_value = acc_f;
			end else begin
				rec.field_value = acc_v;
			end
		end
	end

endmodule

[rtl/protobuf_field_tokenizer_core.sv]
// Channel   Direction  Handshake                Payload
// byte      in         byte_valid / byte_ready  byte_data (in_byte, in_final)
// rec       out        rec_valid / rec_ready    rec_data (one field, error or end record)
//
// One message byte is taken every cycle unless a held record stalls the input stage.
// The per-byte decode sits between the input stage register and the record register.
// Reset returns the decoder to the tag phase with the byte position at zero.
// A held record stalls the input stage, and byte_ready follows rec_ready in that case.
// Bytes that produce no record pass through without touching the record register.
module protobuf_field_tokenizer_core #(
	parameter int POSITION_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_ready,
	input  pft_pkg::in_t    byte_data,
	output logic            rec_valid,
	input  logic            rec_ready,
	output pft_pkg::out_t   rec_data
);
	import pft_pkg::*;

	logic                     valid_s1;
	in_t                      data_s1;
	state_t                   state_q;
	state_t                   state_nxt;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_inc;
	logic                     advance;
	logic                     step_valid;
	out_t                     step_rec;
	logic                     rec_valid_q;
	out_t                     rec_q;

	assign advance    = valid_s1 && (!rec_valid_q || rec_ready);
	assign byte_ready = !valid_s1 || advance;
	assign pos_inc    = pos_q + POSITION_BITS'(1);

	pft_step u_step (
		.cur       (state_q),
		.beat      (data_s1),
		.pos_low   (32'(pos_inc)),
		.nxt       (state_nxt),
		.rec_valid (step_valid),
		.rec       (step_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			pos_q   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			pos_q   <= data_s1.in_final ? '0 : pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (advance && step_valid) begin
			rec_valid_q <= 1'b1;
		end else if (rec_ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			rec_q <= step_rec;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec_data  = rec_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

import pft_pkg::*;

typedef enum {VARINT_MORE, VARINT_DONE, VARINT_LONG} varint_step_t;

class field_scoreboard;
	out_t expected_records[$];
	int errors;

	phase_t phase;
	logic [63:0] acc;
	logic [3:0] count;
	logic [31:0] position;
	logic [28:0] fnum;
	kind_t kind;
	logic [31:0] remaining;
	logic [31:0] pstart;
	bit stopped;

	function new();
		errors = 0;
		clear_message();
	endfunction

	function void clear_message();
		phase = PH_TAG;
		acc = '0;
		count = '0;
		position = '0;
		fnum = '0;
		kind = KIND_VARINT;
		remaining = '0;
		pstart = '0;
		stopped = 0;
	endfunction

	function varint_step_t feed_varint(logic [7:0] b);
		if (count < VARINT_MAX_BYTES) begin
			acc |= 64'(b[6:0]) << (7 * count);
			count++;
		end
		if (!b[7])
			return VARINT_DONE;
		if (count >= VARINT_MAX_BYTES)
			return VARINT_LONG;
		return VARINT_MORE;
	endfunction

	function int pending();
		return expected_records.size();
	endfunction

	function void note_beat(in_t beat);
		logic [7:0] b;
		bit fin;
		bit have;
		status_t st;
		logic [63:0] value;
		logic [63:0] len;
		logic [31:0] off;
		logic [63:0] tag;
		varint_step_t r;
		out_t rec;
		b = beat.in_byte;
		fin = beat.in_final;
		have = 0;
		st = ST_FIELD;
		value = '0;
		len = '0;
		off = '0;
		position = position + 1;
		if (stopped) begin
			if (!fin)
				return;
			have = 1;
			st = ST_END;
		end else begin
			case (phase)
				PH_TAG: begin
					r = feed_varint(b);
					if (r == VARINT_LONG) begin
						have = 1;
						st = ST_LONG;
					end else if (r == VARINT_DONE) begin
						tag = acc;
						acc = '0;
						count = '0;
						if (tag[63:32] != 0) begin
							have = 1;
							st = ST_TAG;
						end else begin
							fnum = tag[31:3];
							if (fnum == 0) begin
								have = 1;
								st = ST_ZERO;
							end else begin
								case (tag[2:0])
									WT_VARINT: begin
										kind = KIND_VARINT;
										phase = PH_VARINT;
									end
									WT_FIXED64: begin
										kind = KIND_FIXED64;
										phase = PH_FIXED;
									end
									WT_LEN: begin
										kind = KIND_LEN;
										phase = PH_LEN;
									end
									WT_FIXED32: begin
										kind = KIND_FIXED32;
										phase = PH_FIXED;
									end
									default: begin
										have = 1;
										st = ST_WIRE;
									end
								endcase
							end
						end
					end
				end
				PH_VARINT: begin
					r = feed_varint(b);
					if (r == VARINT_LONG) begin
						have = 1;
						st = ST_LONG;
					end else if (r == VARINT_DONE) begin
						have = 1;
						value = acc;
					end
				end
				PH_FIXED: begin
					acc |= 64'(b) << (8 * count[2:0]);
					count++;
					if (count >= ((kind == KIND_FIXED64) ? 8 : 4)) begin
						have = 1;
						value = acc;
					end
				end
				PH_LEN: begin
					r = feed_varint(b);
					if (r == VARINT_LONG) begin
						have = 1;
						st = ST_LONG;
					end else if (r == VARINT_DONE) begin
						if (acc[63:32] != 0) begin
							have = 1;
							st = ST_TRUNC;
						end else begin
							pstart = position;
							remaining = acc[31:0];
							if (remaining == 0)
								have = 1;
							else
								phase = PH_SKIP;
						end
					end
				end
				default: begin
					if (remaining > 0)
						remaining--;
					if (remaining == 0)
						have = 1;
				end
			endcase
			if (have && st == ST_FIELD && kind == KIND_LEN) begin
				off = pstart;
				len = acc;
				value = '0;
			end
			if (!have && fin) begin
				have = 1;
				st = ST_TRUNC;
			end
		end
		if (!have)
			return;
		rec = '0;
		if (st == ST_FIELD) begin
			rec.field_id = fnum;
			rec.field_kind = kind;
			rec.field_value = value;
			rec.payload_offset = off;
			rec.payload_length = len[31:0];
			phase = PH_TAG;
			acc = '0;
			count = '0;
			remaining = '0;
		end else begin
			stopped = 1;
		end
		rec.status = st;
		rec.end_of_message = fin;
		if (fin)
			clear_message();
		expected_records.push_back(rec);
	endfunction

	function void report(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check(out_t got);
		out_t want;
		if (expected_records.size() == 0) begin
			$display("%0t unexpected record: expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = expected_records.pop_front();
		report("field_id", want.field_id, got.field_id);
		report("field_kind", want.field_kind, got.field_kind);
		report("field_value", want.field_value, got.field_value);
		report("payload_offset", want.payload_offset, got.payload_offset);
		report("payload_length", want.payload_length, got.payload_length);
		report("status", want.status, got.status);
		report("end_of_message", want.end_of_message, got.end_of_message);
	endfunction
endclass

module tb_top;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int BEATS_PER_PHASE = 480;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	in_t byte_data = '0;
	logic rec_valid;
	logic rec_ready = 1'b0;
	out_t rec_data;

	int send_idle_pct = 0;
	int rec_stall_pct = 0;
	int quiet_cycles = 0;
	int phase_beats;
	int idle_plan[4] = '{0, 85, 0, 20};
	int stall_plan[4] = '{0, 0, 85, 20};
	logic [7:0] msg[$];
	field_scoreboard sb;

	protobuf_field_tokenizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec_data(rec_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rec_ready <= ($urandom_range(99) >= rec_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready)
				sb.note_beat(byte_data);
			if (rec_valid && rec_ready)
				sb.check(rec_data);
			if ((byte_valid && byte_ready) || (rec_valid && rec_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	function int pick_pad();
		return ($urandom_range(9) == 0) ? $urandom_range(1, 9) : 0;
	endfunction

	function void put_varint(logic [63:0] v, int pad);
		int n;
		logic [7:0] bv;
		n = 1;
		while (n < 10 && (v >> (7 * n)) != 0)
			n++;
		n = (n + pad > 10) ? 10 : n + pad;
		for (int i = 0; i < n; i++) begin
			bv = {1'b0, 7'(v >> (7 * i))};
			if (i < n - 1)
				bv[7] = 1'b1;
			if (i == 9)
				bv[6:1] = 6'($urandom);
			msg.push_back(bv);
		end
	endfunction

	function void put_tag(logic [28:0] fn, logic [2:0] wt, int pad);
		put_varint({32'd0, fn, wt}, pad);
	endfunction

	function void put_long_varint();
		repeat (10 + $urandom_range(2))
			msg.push_back(8'h80 | 8'($urandom));
	endfunction

	function void put_field();
		logic [28:0] fn;
		logic [63:0] value;
		int len;
		case ($urandom_range(3))
			0: fn = 29'($urandom_range(1, 15));
			1: fn = 29'($urandom_range(16, 2047));
			2: fn = 29'($urandom) | 29'd1;
			default: fn = '1;
		endcase
		case ($urandom_range(3))
			0: begin
				put_tag(fn, WT_VARINT, pick_pad());
				value = {$urandom, $urandom} >> $urandom_range(63);
				if ($urandom_range(15) == 0)
					value = '1;
				put_varint(value, pick_pad());
			end
			1: begin
				put_tag(fn, WT_FIXED64, pick_pad());
				repeat (8)
					msg.push_back(8'($urandom));
			end
			2: begin
				put_tag(fn, WT_LEN, pick_pad());
				len = ($urandom_range(15) == 0) ? $urandom_range(7, 40) : $urandom_range(6);
				put_varint(len, pick_pad());
				repeat (len)
					msg.push_back(8'($urandom));
			end
			default: begin
				put_tag(fn, WT_FIXED32, pick_pad());
				repeat (4)
					msg.push_back(8'($urandom));
			end
		endcase
	endfunction

	function void put_fault();
		logic [2:0] wt;
		logic [63:0] tag;
		case ($urandom_range(7))
			0: begin
				do
					wt = 3'($urandom);
				while (wt inside {WT_VARINT, WT_FIXED64, WT_LEN, WT_FIXED32});
				put_tag(29'($urandom) | 29'd1, wt, pick_pad());
			end
			1: put_tag('0, 3'($urandom), pick_pad());
			2: begin
				tag = {$urandom, $urandom};
				tag[63:32] = ($urandom | 1) >> $urandom_range(31);
				put_varint(tag, pick_pad());
			end
			3: put_long_varint();
			4: begin
				put_tag(29'($urandom_range(1, 100)), WT_VARINT, 0);
				put_long_varint();
			end
			5: begin
				put_tag(29'($urandom_range(1, 100)), WT_LEN, 0);
				put_long_varint();
			end
			6: begin
				put_tag(29'($urandom_range(1, 100)), WT_LEN, 0);
				tag = {$urandom, $urandom};
				tag[63:32] = ($urandom | 1) >> $urandom_range(31);
				put_varint(tag, pick_pad());
			end
			default: begin
				repeat ($urandom_range(1, 8))
					msg.push_back(8'($urandom));
			end
		endcase
		repeat ($urandom_range(4))
			msg.push_back(8'($urandom));
	endfunction

	function void build_message();
		int cut;
		msg.delete();
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(3))
				put_field();
			put_fault();
		end else begin
			repeat ($urandom_range(1, 4))
				put_field();
			if ($urandom_range(99) < 8) begin
				cut = $urandom_range(1, msg.size());
				while (msg.size() > cut)
					void'(msg.pop_back());
			end
		end
	endfunction

	task automatic send_beat(logic [7:0] b, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{in_byte: b, in_final: fin};
		do
			@(posedge clk);
		while (!byte_ready);
		phase_beats++;
	endtask

	task automatic send_message();
		int last;
		last = msg.size() - 1;
		for (int i = 0; i <= last; i++)
			send_beat(msg[i], i == last);
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		msg.delete();
		put_tag(29'd1, WT_VARINT, 0);
		put_varint(64'd150, 0);
		put_tag(29'd2, WT_FIXED32, 0);
		msg.push_back(8'hFF);
		msg.push_back(8'h00);
		msg.push_back(8'h00);
		msg.push_back(8'h80);
		put_tag(29'd3, WT_LEN, 0);
		put_varint(64'd0, 0);
		put_tag('1, WT_FIXED64, 0);
		repeat (8)
			msg.push_back(8'hFF);
		send_message();
		msg.delete();
		put_tag('0, WT_VARINT, 0);
		msg.push_back(8'h55);
		send_message();
		msg.delete();
		put_tag(29'd4, WT_LEN, 0);
		put_varint(64'd2, 0);
		msg.push_back(8'hAA);
		send_message();
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_plan[p];
			rec_stall_pct = stall_plan[p];
			phase_beats = 0;
			while (phase_beats < BEATS_PER_PHASE) begin
				build_message();
				send_message();
			end
			drain();
		end

		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
